FILE: hw/rtl/utf8_levenshtein_distance_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 edit distance assertion macros
// Clocked, reset-gated property shorthands used by the top level.
// ----------------------------------------------------------------------------
`ifndef UTF8_LEVENSHTEIN_DISTANCE_MACROS_SVH
`define UTF8_LEVENSHTEIN_DISTANCE_MACROS_SVH

// same-cycle implication
`define ULEV_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ULEV_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ulev_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 edit distance package
// Shared types, widths and the UTF-8 lead byte decoder.
// ----------------------------------------------------------------------------
package ulev_pkg;

   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int CHAR_W = 48;   // up to six bytes, first byte in the MSBs
   localparam int LEFT_W = 3;
   localparam int DIST_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_FIRST  = 2'd0,
      CMD_SECOND = 2'd1,
      CMD_END    = 2'd2
   } cmd_type;

   typedef enum logic {
      PH_FIRST  = 1'b0,
      PH_SECOND = 1'b1
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PRIME,
      S_ROW,
      S_FIN_RD,
      S_FIN
   } state_type;

   // continuation bytes still due after a lead byte (0..5)
   function automatic logic [LEFT_W-1:0] lead_extra(input logic [BYTE_W-1:0] b);
      logic [LEFT_W-1:0] n;
      logic              run;
      n   = '0;
      run = b[7];
      for (int k = 0; k < 5; k++) begin
         if (run && b[6-k]) begin
            n = n + LEFT_W'(1);
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

endpackage

FILE: hw/rtl/ulev_req_if.sv
// ----------------------------------------------------------------------------
// UTF-8 edit distance request channel
// Valid/ready channel carrying one command and one byte per request.
// ----------------------------------------------------------------------------
interface ulev_req_if
   import ulev_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, command, data_byte, input ready);
   modport sink   (input valid, command, data_byte, output ready);
endinterface

FILE: hw/rtl/ulev_rsp_if.sv
// ----------------------------------------------------------------------------
// UTF-8 edit distance response channel
// Valid/ready channel carrying the distance and the truncation flag.
// ----------------------------------------------------------------------------
interface ulev_rsp_if
   import ulev_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic              too_long;

   modport source (output valid, distance, too_long, input ready);
   modport sink   (input valid, distance, too_long, output ready);
endinterface

FILE: hw/rtl/utf8_levenshtein_distance.sv
// ----------------------------------------------------------------------------
// UTF-8 Levenshtein edit distance
// Byte-serial UTF-8 decoder with a row-walking edit distance engine.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per byte: command FIRST with a byte of the first
//   string, SECOND with a byte of the second string, END to close the pair.
//   Bytes are grouped into UTF-8 characters (1..6 bytes by the lead byte).
//   rsp carries one response per END: the distance and a too_long flag set
//   when either string was cut at MAX_CHARS characters.
// Timing:
//   req is ready only while idle. A byte that finishes a second-string
//   character starts a row walk: a read-prime step, then one cost-row cell
//   per cycle through the single min/add unit and the one read port of each
//   memory, with req not ready. END passes a final read state and the final
//   state (after a row walk if it completes a cut-short character); the
//   response register then frees req again.
// Reset: synchronous; counters, phase and the response valid clear at once.
//   Character and cost memories are not cleared; cost row contents are only
//   read once the current pair has written them.
// Stall: while rsp is stalled the block still takes bytes; an END waits in
//   its final state until the response register is free.
// ----------------------------------------------------------------------------
`include "utf8_levenshtein_distance_macros.svh"

module utf8_levenshtein_distance
   import ulev_pkg::*;
#(
   parameter int MAX_CHARS = 64
) (
   input  logic       clock,
   input  logic       reset,
   ulev_req_if.sink   req,
   ulev_rsp_if.source rsp
);

   localparam int CW = $clog2(MAX_CHARS + 1);                  // count width
   localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1; // memory index

   // first string characters and cost row cells 1..MAX_CHARS
   logic [CHAR_W-1:0] first_mem [MAX_CHARS];
   logic [CW-1:0]     cost_mem  [MAX_CHARS];

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [CW-1:0]     first_count_ff, first_count_in;
   logic [CW-1:0]     second_count_ff, second_count_in;
   logic [CHAR_W-1:0] pending_ff, pending_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic              overflow_ff, overflow_in;
   logic              end_ff, end_in;          // END is waiting behind a row walk
   logic              first_row_ff, first_row_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;            // second-string character in flight
   logic [AW-1:0]     idx_ff, idx_in;          // cell being computed
   logic [CW-1:0]     diag_ff, diag_in;        // old row[j-1]
   logic [CW-1:0]     lcost_ff, lcost_in;      // new row[j-1]
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_long_ff, rsp_long_in;

   // memory ports
   logic              fm_we;
   logic [AW-1:0]     fm_waddr;
   logic [CHAR_W-1:0] fm_wdata;
   logic              cm_we;
   logic [AW-1:0]     cm_waddr;
   logic [CW-1:0]     cm_wdata;
   logic [AW-1:0]     rd_addr;
   logic [CHAR_W-1:0] char_rd_ff;
   logic [CW-1:0]     cost_rd_ff;

   assign req.ready    = (state_ff == S_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.distance = rsp_dist_ff;
   assign rsp.too_long = rsp_long_ff;

   always_comb begin
      logic [CHAR_W-1:0] flushed;
      logic [CHAR_W-1:0] cur_pend;
      logic [LEFT_W-1:0] cur_left;
      logic [CHAR_W-1:0] np;
      logic [LEFT_W-1:0] nl;
      logic              c1_req;
      logic [CHAR_W-1:0] c1_val;
      logic              c2_req;
      logic [CHAR_W-1:0] c2_val;
      logic [CW:0]       up_w;
      logic [CW:0]       sub_w;
      logic [CW:0]       ins_w;
      logic [CW:0]       best_w;
      logic [CW-1:0]     dist_sel;
      logic [CW+DIST_W-1:0] dist_w;

      state_in        = state_ff;
      phase_in        = phase_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      pending_in      = pending_ff;
      left_in         = left_ff;
      overflow_in     = overflow_ff;
      end_in          = end_ff;
      first_row_in    = first_row_ff;
      ch_in           = ch_ff;
      idx_in          = idx_ff;
      diag_in         = diag_ff;
      lcost_in        = lcost_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_dist_in     = rsp_dist_ff;
      rsp_long_in     = rsp_long_ff;
      fm_we           = 1'b0;
      fm_waddr        = first_count_ff[AW-1:0];
      fm_wdata        = '0;
      cm_we           = 1'b0;
      cm_waddr        = idx_ff;
      cm_wdata        = '0;
      rd_addr         = '0;

      // a cut-short character is padded with zero bytes
      flushed  = pending_ff << {left_ff, 3'b000};
      cur_pend = pending_ff;
      cur_left = left_ff;
      np       = '0;
      nl       = '0;
      c1_req   = 1'b0;
      c1_val   = '0;
      c2_req   = 1'b0;
      c2_val   = '0;
      up_w     = '0;
      sub_w    = '0;
      ins_w    = '0;
      best_w   = '0;
      dist_sel = '0;
      dist_w   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               // second string opens or END arrives: close any open first-string character
               if (((req.command == CMD_SECOND) || (req.command == CMD_END)) &&
                   (phase_ff == PH_FIRST) && (left_ff != '0)) begin
                  c1_req = 1'b1;
                  c1_val = flushed;
               end
               if ((req.command == CMD_SECOND) && (phase_ff == PH_FIRST)) begin
                  cur_pend = '0;
                  cur_left = '0;
               end
               if (cur_left == '0) begin
                  np = {{(CHAR_W-BYTE_W){1'b0}}, req.data_byte};
                  nl = lead_extra(req.data_byte);
               end else begin
                  np = {cur_pend[CHAR_W-BYTE_W-1:0], req.data_byte};
                  nl = cur_left - LEFT_W'(1);
               end

               unique case (req.command)
                  CMD_FIRST: begin
                     if (phase_ff == PH_FIRST) begin
                        pending_in = (nl == '0) ? '0 : np;
                        left_in    = nl;
                        c1_req     = (nl == '0);
                        c1_val     = np;
                     end
                  end
                  CMD_SECOND: begin
                     phase_in   = PH_SECOND;
                     pending_in = (nl == '0) ? '0 : np;
                     left_in    = nl;
                     c2_req     = (nl == '0);
                     c2_val     = np;
                  end
                  CMD_END: begin
                     state_in   = S_FIN_RD;
                     end_in     = 1'b1;
                     pending_in = '0;
                     left_in    = '0;
                     if ((phase_ff == PH_SECOND) && (left_ff != '0)) begin
                        c2_req = 1'b1;
                        c2_val = flushed;
                     end
                  end
                  default: begin
                  end
               endcase

               // store a first-string character
               if (c1_req) begin
                  if (first_count_ff < CW'(MAX_CHARS)) begin
                     fm_we          = 1'b1;
                     fm_wdata       = c1_val;
                     first_count_in = first_count_ff + CW'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               // launch a row walk for a second-string character
               if (c2_req) begin
                  if (second_count_ff == CW'(MAX_CHARS)) begin
                     overflow_in = 1'b1;
                  end else begin
                     second_count_in = second_count_ff + CW'(1);
                     if (first_count_in != '0) begin
                        ch_in        = c2_val;
                        diag_in      = second_count_ff;
                        lcost_in     = second_count_ff + CW'(1);
                        first_row_in = (second_count_ff == '0);
                        state_in     = S_PRIME;
                     end
                  end
               end
            end
         end

         S_PRIME: begin
            rd_addr  = '0;
            idx_in   = '0;
            state_in = S_ROW;
         end

         S_ROW: begin
            // row 0 is implicit: up = j on the first row
            up_w   = first_row_ff ? ({1'b0, CW'(idx_ff)} + (CW+1)'(1))
                                  : {1'b0, cost_rd_ff};
            sub_w  = {1'b0, diag_ff} + (CW+1)'(ch_ff != char_rd_ff);
            ins_w  = {1'b0, lcost_ff} + (CW+1)'(1);
            best_w = sub_w;
            if (ins_w < best_w) begin
               best_w = ins_w;
            end
            if ((up_w + (CW+1)'(1)) < best_w) begin
               best_w = up_w + (CW+1)'(1);
            end
            cm_we    = 1'b1;
            cm_waddr = idx_ff;
            cm_wdata = best_w[CW-1:0];
            diag_in  = up_w[CW-1:0];
            lcost_in = best_w[CW-1:0];
            rd_addr  = idx_ff + AW'(1);
            idx_in   = idx_ff + AW'(1);
            if ((CW'(idx_ff) + CW'(1)) == first_count_ff) begin
               state_in = end_ff ? S_FIN_RD : S_IDLE;
            end
         end

         S_FIN_RD: begin
            rd_addr  = AW'(first_count_ff - CW'(1));
            state_in = S_FIN;
         end

         S_FIN: begin
            priority if (second_count_ff == '0) begin
               dist_sel = first_count_ff;
            end else if (first_count_ff == '0) begin
               dist_sel = second_count_ff;
            end else begin
               dist_sel = cost_rd_ff;
            end
            dist_w = {{DIST_W{1'b0}}, dist_sel};
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_dist_in     = dist_w[DIST_W-1:0];
               rsp_long_in     = overflow_ff;
               state_in        = S_IDLE;
               phase_in        = PH_FIRST;
               first_count_in  = '0;
               second_count_in = '0;
               pending_in      = '0;
               left_in         = '0;
               overflow_in     = 1'b0;
               end_in          = 1'b0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         phase_ff        <= PH_FIRST;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         left_ff         <= '0;
         overflow_ff     <= 1'b0;
         end_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         left_ff         <= left_in;
         overflow_ff     <= overflow_in;
         end_ff          <= end_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff   <= pending_in;
      first_row_ff <= first_row_in;
      ch_ff        <= ch_in;
      idx_ff       <= idx_in;
      diag_ff      <= diag_in;
      lcost_ff     <= lcost_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_long_ff  <= rsp_long_in;
   end

   // character store: one write, one registered read
   always_ff @(posedge clock) begin
      if (fm_we) begin
         first_mem[fm_waddr] <= fm_wdata;
      end
      char_rd_ff <= first_mem[rd_addr];
   end

   // cost row: write cell j while reading cell j+1
   always_ff @(posedge clock) begin
      if (cm_we) begin
         cost_mem[cm_waddr] <= cm_wdata;
      end
      cost_rd_ff <= cost_mem[rd_addr];
   end

   `ULEV_ASSERT_NOW(a_row_in_range, state_ff == S_ROW, CW'(idx_ff) < first_count_ff,
                    "row walk past stored characters")
   `ULEV_ASSERT_NOW(a_count_bound, 1'b1,
                    (first_count_ff <= CW'(MAX_CHARS)) && (second_count_ff <= CW'(MAX_CHARS)),
                    "character count above limit")
   `ULEV_ASSERT_NEXT(a_rsp_source, (state_ff != S_FIN) && !rsp_valid_ff, !rsp_valid_ff,
                     "response raised outside final state")
   `ULEV_ASSERT_NOW(a_left_bound, 1'b1, left_ff <= LEFT_W'(5),
                    "more than five continuation bytes due")

endmodule

FILE: dv/tb_utf8_levenshtein_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 edit distance testbench
// Sends string pairs byte by byte on the request channel and checks every
// distance response against an edit distance predictor kept in the bench.
// Directed pairs come first, then random pairs built from small per-pair
// alphabets, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_utf8_levenshtein_distance;
   import ulev_pkg::*;

   localparam int MAX_CHARS   = 64;
   localparam int N_ITEMS     = 1800;
   localparam int MIN_PAIRS   = 60;
   localparam int IDLE_LIMIT  = 3000;
   localparam int TAIL_CYCLES = 2 * MAX_CHARS + 20;
   localparam int MAX_REPORTS = 10;
   // the one command code outside the defined set; the block ignores it
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   typedef logic [CHAR_W-1:0] char_bits_type;

   // one UTF-8 character as sent: byte k sits in data[8*k +: 8]
   typedef struct {
      logic [CHAR_W-1:0] data;
      int                len;
   } utf8_char_type;

   typedef struct {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] data_byte;
      bit                drain_first;   // hold off until all distances are back
   } request_type;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic              too_long;
   } distance_type;

   typedef enum {
      RDY_ALWAYS,
      RDY_HALF,
      RDY_SPARSE,
      RDY_PATTERN
   } ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ulev_req_if req ();
   ulev_rsp_if rsp ();

   utf8_levenshtein_distance #(
      .MAX_CHARS(MAX_CHARS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Edit distance predictor
   // -------------------------------------------------------------------------
   char_bits_type  ed_first_chars [MAX_CHARS];
   int             ed_row [MAX_CHARS+1];
   int             ed_first_n;
   int             ed_second_n;
   char_bits_type  ed_pending;
   int             ed_left;         // bytes still due for the pending character
   bit             ed_truncated;
   phase_type      ed_phase;

   distance_type   expected_dist_q [$];

   // character and row stores keep their contents, as in the block
   task automatic ed_clear();
      ed_first_n   = 0;
      ed_second_n  = 0;
      ed_pending   = '0;
      ed_left      = 0;
      ed_truncated = 1'b0;
      ed_phase     = PH_FIRST;
   endtask

   // continuation bytes announced by a lead byte: run of ones below bit 7,
   // at most five of them
   function automatic int continuation_count(logic [BYTE_W-1:0] b);
      int n;
      n = 0;
      if (b[7]) begin
         while (n < 5 && b[6-n]) begin
            n++;
         end
      end
      return n;
   endfunction

   // one row of the distance matrix for a second-string character
   task automatic ed_advance_row(char_bits_type ch);
      int diag;
      int up;
      int best;
      if (ed_second_n >= MAX_CHARS) begin
         ed_truncated = 1'b1;
         return;
      end
      ed_second_n++;
      diag      = ed_row[0];
      ed_row[0] = ed_second_n;
      for (int j = 1; j <= ed_first_n; j++) begin
         up   = ed_row[j];
         best = diag + ((ch == ed_first_chars[j-1]) ? 0 : 1);
         if (ed_row[j-1] + 1 < best) begin
            best = ed_row[j-1] + 1;
         end
         if (up + 1 < best) begin
            best = up + 1;
         end
         ed_row[j] = best;
         diag      = up;
      end
   endtask

   task automatic ed_commit();
      char_bits_type ch;
      ch         = ed_pending;
      ed_pending = '0;
      ed_left    = 0;
      if (ed_phase == PH_FIRST) begin
         if (ed_first_n < MAX_CHARS) begin
            ed_first_chars[ed_first_n] = ch;
            ed_first_n++;
         end else begin
            ed_truncated = 1'b1;
         end
      end else begin
         ed_advance_row(ch);
      end
   endtask

   // a character cut short gets zero bytes for whatever is missing
   task automatic ed_flush();
      if (ed_left != 0) begin
         ed_pending = ed_pending << (8 * ed_left);
         ed_commit();
      end
   endtask

   task automatic ed_take_byte(logic [BYTE_W-1:0] b);
      if (ed_left == 0) begin
         ed_pending = char_bits_type'(b);
         ed_left    = continuation_count(b);
      end else begin
         ed_pending = {ed_pending[CHAR_W-BYTE_W-1:0], b};
         ed_left--;
      end
      if (ed_left == 0) begin
         ed_commit();
      end
   endtask

   task automatic ed_open_second();
      ed_flush();
      for (int j = 0; j <= ed_first_n; j++) begin
         ed_row[j] = j;
      end
      ed_phase = PH_SECOND;
   endtask

   task automatic ed_apply(request_type r);
      distance_type res;
      case (r.command)
         CMD_FIRST: begin
            // first-string bytes are dropped once the second string began
            if (ed_phase == PH_FIRST) begin
               ed_take_byte(r.data_byte);
            end
         end
         CMD_SECOND: begin
            if (ed_phase == PH_FIRST) begin
               ed_open_second();
            end
            ed_take_byte(r.data_byte);
         end
         CMD_END: begin
            if (ed_phase == PH_FIRST) begin
               ed_open_second();
            end else begin
               ed_flush();
            end
            res.distance = DIST_W'(ed_row[ed_first_n]);
            res.too_long = ed_truncated;
            expected_dist_q.insert(expected_dist_q.size(), res);
            ed_clear();
         end
         default: begin
         end
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Request list
   // -------------------------------------------------------------------------
   request_type pending_req_q [$];
   bit          drain_next;     // tags the next request queued
   int          n_counted;      // requests other than the unused command
   int          n_pairs;

   task automatic add_req(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
      request_type r;
      r.command     = cmd;
      r.data_byte   = b;
      r.drain_first = drain_next;
      drain_next    = 1'b0;
      pending_req_q.insert(pending_req_q.size(), r);
      if (cmd != CMD_NONE) begin
         n_counted++;
      end
   endtask

   // well-formed character most of the time; stray leads and odd
   // continuation bytes now and then
   function automatic utf8_char_type rand_char();
      utf8_char_type     c;
      int                sel;
      logic [BYTE_W-1:0] mask;
      c.data = '0;
      sel    = $urandom_range(0, 99);
      if (sel < 45)      c.len = 1;
      else if (sel < 65) c.len = 2;
      else if (sel < 80) c.len = 3;
      else if (sel < 88) c.len = 4;
      else if (sel < 94) c.len = 5;
      else               c.len = 6;
      if (c.len == 1) begin
         if ($urandom_range(0, 9) == 0) begin
            c.data[7:0] = 8'h80 | 8'($urandom_range(0, 63));   // stray lead
         end else begin
            c.data[7:0] = 8'($urandom_range(0, 127));
         end
      end else if (c.len == 6) begin
         c.data[7:0] = 8'hFC | 8'($urandom_range(0, 3));
      end else begin
         mask        = 8'hFF >> c.len;
         c.data[7:0] = ~mask | (8'($urandom) & (mask >> 1));
      end
      for (int k = 1; k < c.len; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            c.data[8*k +: 8] = 8'($urandom);
         end else begin
            c.data[8*k +: 8] = 8'h80 | 8'($urandom_range(0, 63));
         end
      end
      return c;
   endfunction

   // send a string; the last character is sometimes cut short, and ignored
   // requests are sprinkled in as noise
   task automatic send_string(logic [CMD_W-1:0] cmd, utf8_char_type s [$]);
      int n_bytes;
      for (int i = 0; i < s.size(); i++) begin
         if ($urandom_range(0, 32) == 0) begin
            add_req(CMD_NONE, 8'($urandom));
         end
         if (cmd == CMD_SECOND && $urandom_range(0, 32) == 0) begin
            add_req(CMD_FIRST, 8'($urandom));
         end
         n_bytes = s[i].len;
         if (i == s.size() - 1 && n_bytes > 1 && $urandom_range(0, 6) == 0) begin
            n_bytes = $urandom_range(1, s[i].len - 1);
         end
         for (int k = 0; k < n_bytes; k++) begin
            add_req(cmd, s[i].data[8*k +: 8]);
         end
      end
   endtask

   task automatic add_pair(bit big);
      utf8_char_type alphabet [8];
      utf8_char_type s1 [$];
      utf8_char_type s2 [$];
      utf8_char_type c;
      int            n_alpha;
      int            n1;
      int            n2;
      int            mode;
      int            pos;
      n_alpha = $urandom_range(1, 8);
      for (int k = 0; k < n_alpha; k++) begin
         alphabet[k] = rand_char();
      end
      n1 = big ? $urandom_range(60, 68) : $urandom_range(0, 10);
      for (int k = 0; k < n1; k++) begin
         c = ($urandom_range(0, 9) == 0) ? rand_char()
                                         : alphabet[$urandom_range(0, n_alpha - 1)];
         s1.insert(s1.size(), c);
      end
      mode = $urandom_range(0, 19);
      if (mode < 10) begin
         // near copy: a few substitutions, deletions and insertions
         s2 = s1;
         repeat ($urandom_range(0, 4)) begin
            c = ($urandom_range(0, 3) == 0) ? rand_char()
                                            : alphabet[$urandom_range(0, n_alpha - 1)];
            case ($urandom_range(0, 2))
               0: begin
                  if (s2.size() > 0) begin
                     s2[$urandom_range(0, s2.size() - 1)] = c;
                  end
               end
               1: begin
                  if (s2.size() > 0) begin
                     s2.delete($urandom_range(0, s2.size() - 1));
                  end
               end
               default: begin
                  pos = $urandom_range(0, s2.size());
                  s2.insert(pos, c);
               end
            endcase
         end
      end else if (mode < 19) begin
         n2 = big ? $urandom_range(60, 68) : $urandom_range(0, 10);
         for (int k = 0; k < n2; k++) begin
            c = ($urandom_range(0, 9) == 0) ? rand_char()
                                            : alphabet[$urandom_range(0, n_alpha - 1)];
            s2.insert(s2.size(), c);
         end
      end
      // otherwise the second string stays empty
      send_string(CMD_FIRST, s1);
      send_string(CMD_SECOND, s2);
      add_req(CMD_END, 8'($urandom));
   endtask

   // -------------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps
   // -------------------------------------------------------------------------
   request_type cur_req;
   int          burst_left;
   int          gap_left;

   always @(posedge clock) begin : req_driver
      if (reset) begin
         req.valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
         ed_clear();
      end else begin
         // the predictor runs in this block, so an END is on the expected
         // list before the hold-off below looks at it
         if (req.valid && req.ready) begin
            ed_apply(cur_req);
         end
         if (!req.valid || req.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (pending_req_q.size() == 0 ||
                         (pending_req_q[0].drain_first &&
                          expected_dist_q.size() != 0)) begin
               req.valid <= 1'b0;
            end else begin
               cur_req        = pending_req_q.pop_front();
               req.valid     <= 1'b1;
               req.command   <= cur_req.command;
               req.data_byte <= cur_req.data_byte;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor, receiver stalls and the no-progress watchdog
   // -------------------------------------------------------------------------
   ready_mode_type ready_mode;
   int             mode_left;
   int             ready_tick;
   int             n_errors;
   int             n_responses;
   int             idle_cycles;

   always @(posedge clock) begin : rsp_monitor
      distance_type want;
      if (reset) begin
         rsp.ready   <= 1'b0;
         idle_cycles = 0;
         mode_left   = 0;
         ready_tick  = 0;
         n_errors    = 0;
         n_responses = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_dist_q.size() == 0) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS) begin
                  $display("ERROR: unexpected response %0d: distance=%0d too_long=%0b",
                           n_responses, rsp.distance, rsp.too_long);
               end
            end else begin
               want = expected_dist_q.pop_front();
               if (rsp.distance !== want.distance || rsp.too_long !== want.too_long) begin
                  n_errors++;
                  if (n_errors <= MAX_REPORTS) begin
                     $display({"ERROR: response %0d: distance exp %0d got %0d, ",
                               "too_long exp %0b got %0b"},
                              n_responses, want.distance, rsp.distance,
                              want.too_long, rsp.too_long);
                  end
               end
            end
            n_responses++;
         end

         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
         end else begin
            // pick a new stall mode when the current one runs out
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            ready_tick++;
            case (ready_mode)
               RDY_ALWAYS: rsp.ready <= 1'b1;
               RDY_HALF:   rsp.ready <= 1'($urandom_range(0, 1));
               RDY_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
               default:    rsp.ready <= (ready_tick % 7 < 3);
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      n_counted = 0;
      n_pairs   = 0;

      // six-byte lead, continuation bytes of every shape, stray lead in the
      // second string, a late first-string byte, an unused command, and a
      // second string that ends inside a three-byte character
      drain_next = 1'b1;
      add_req(CMD_FIRST, 8'h41);
      add_req(CMD_FIRST, 8'hFF);
      add_req(CMD_FIRST, 8'h00);
      add_req(CMD_FIRST, 8'hFF);
      add_req(CMD_FIRST, 8'h7F);
      add_req(CMD_FIRST, 8'h80);
      add_req(CMD_FIRST, 8'hC0);
      add_req(CMD_SECOND, 8'h80);
      add_req(CMD_FIRST, 8'h41);
      add_req(CMD_NONE, 8'h5A);
      add_req(CMD_SECOND, 8'hE2);
      add_req(CMD_SECOND, 8'h82);
      add_req(CMD_END, 8'hFF);
      // first string cut short by the first second-string byte
      add_req(CMD_FIRST, 8'hC3);
      add_req(CMD_SECOND, 8'h00);
      add_req(CMD_SECOND, 8'h7F);
      add_req(CMD_END, 8'h00);
      // empty second string
      add_req(CMD_FIRST, 8'h61);
      add_req(CMD_FIRST, 8'h62);
      add_req(CMD_END, 8'h00);
      // both strings empty, after an ignored request
      add_req(CMD_NONE, 8'hA5);
      add_req(CMD_END, 8'h00);
      // equal two-byte characters
      add_req(CMD_FIRST, 8'hDF);
      add_req(CMD_FIRST, 8'hBF);
      add_req(CMD_SECOND, 8'hDF);
      add_req(CMD_SECOND, 8'hBF);
      add_req(CMD_END, 8'h00);

      // random pairs; some long enough to truncate, and every eighth pair
      // waits for all outstanding distances first
      while (n_counted < N_ITEMS || n_pairs < MIN_PAIRS) begin
         drain_next = (n_pairs % 8 == 0);
         add_pair(n_pairs == 5 || n_pairs == 30 || $urandom_range(0, 11) == 0);
         n_pairs++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_req_q.size() != 0 || req.valid || expected_dist_q.size() != 0) begin
         @(posedge clock);
      end
      // catch any late, unexpected response
      repeat (TAIL_CYCLES) @(posedge clock);

      if (n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ulev_pkg.sv
hw/rtl/ulev_req_if.sv
hw/rtl/ulev_rsp_if.sv
hw/rtl/utf8_levenshtein_distance.sv
dv/tb_utf8_levenshtein_distance.sv
